### hdl/lmts_pkg.sv
// Package for the LCD mode timing sequencer.
// Mode codes, dot budgets, line limits and register indexes; no dependencies.
`default_nettype none

package lmts_pkg;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   localparam int LINE_WIDTH  = 8;
   localparam int DOT_WIDTH   = 9;
   localparam int CSR_WIDTH   = 8;
   localparam int INDEX_WIDTH = 3;

   localparam logic [DOT_WIDTH-1:0]  DOTS_OAM     = 9'd80;
   localparam logic [DOT_WIDTH-1:0]  DOTS_XFER    = 9'd172;
   localparam logic [DOT_WIDTH-1:0]  DOTS_HBLANK  = 9'd204;
   localparam logic [DOT_WIDTH-1:0]  DOTS_LINE    = 9'd456;
   localparam logic [LINE_WIDTH-1:0] FIRST_VBLANK = 8'd144;
   localparam logic [LINE_WIDTH-1:0] LAST_LINE    = 8'd153;

   localparam logic [INDEX_WIDTH-1:0] REG_HBLANK_IRQ_EN  = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] REG_VBLANK_IRQ_EN  = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] REG_OAM_IRQ_EN     = 3'd2;
   localparam logic [INDEX_WIDTH-1:0] REG_COMPARE_IRQ_EN = 3'd3;
   localparam logic [INDEX_WIDTH-1:0] REG_COMPARE_VALUE  = 3'd4;

endpackage

`default_nettype wire

### hdl/lcd_mode_timing_sequencer_unit.sv
// A tick's result is registered in the result register and shown on the rsp outputs.
// Throughput: one tick per cycle while no result is held by rsp_stall; the mode/dot/line registers update in one pass.
// The result register holds a stalled result while the next tick is still accepted
// once that result is taken (stall passes straight through from rsp to req).
// Reset (synchronous): mode 0, dot count 0, line 0, line-drawn clear, all enables 0.
// Depends on lmts_pkg.
`default_nettype none

module lcd_mode_timing_sequencer_unit (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_write_enable,
   input  wire  [lmts_pkg::INDEX_WIDTH-1:0]       csr_index,
   input  wire  [lmts_pkg::CSR_WIDTH-1:0]         csr_write_data,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire                                    req_lcd_enable,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic [lmts_pkg::LINE_WIDTH-1:0]        rsp_line_number,
   output logic [1:0]                             rsp_mode,
   output logic                                   rsp_line_match,
   output logic                                   rsp_stat_irq,
   output logic                                   rsp_vblank_irq,
   output logic                                   rsp_draw_line_strobe
);

   // configuration
   logic                              hblank_en_ff, vblank_en_ff, oam_en_ff, compare_en_ff;
   logic [lmts_pkg::LINE_WIDTH-1:0]   compare_ff;

   // sequencer state
   lmts_pkg::mode_type                mode_ff, mode_in;
   logic [lmts_pkg::DOT_WIDTH-1:0]    dot_ff, dot_in, dot_base;
   logic [lmts_pkg::LINE_WIDTH-1:0]   line_ff, line_in, line_inc;
   logic                              drawn_ff, drawn_in;

   // result register
   logic                              valid_ff, valid_in;
   logic [lmts_pkg::LINE_WIDTH-1:0]   line_out_ff;
   logic [1:0]                        mode_out_ff;
   logic                              match_ff, stat_ff, vbl_ff, strobe_ff;
   logic                              match_in, stat_in, vbl_in, strobe_in;

   logic                              accept;

   assign req_stall = valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         hblank_en_ff  <= 1'b0;
         vblank_en_ff  <= 1'b0;
         oam_en_ff     <= 1'b0;
         compare_en_ff <= 1'b0;
         compare_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lmts_pkg::REG_HBLANK_IRQ_EN:  hblank_en_ff  <= csr_write_data[0];
            lmts_pkg::REG_VBLANK_IRQ_EN:  vblank_en_ff  <= csr_write_data[0];
            lmts_pkg::REG_OAM_IRQ_EN:     oam_en_ff     <= csr_write_data[0];
            lmts_pkg::REG_COMPARE_IRQ_EN: compare_en_ff <= csr_write_data[0];
            lmts_pkg::REG_COMPARE_VALUE:  compare_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign line_inc = line_ff + 8'd1;

   always_comb begin
      mode_in   = mode_ff;
      dot_base  = dot_ff;
      line_in   = line_ff;
      drawn_in  = drawn_ff;
      match_in  = 1'b0;
      stat_in   = 1'b0;
      vbl_in    = 1'b0;
      strobe_in = 1'b0;
      if (!req_lcd_enable) begin
         mode_in  = lmts_pkg::MODE_HBLANK;
         dot_base = '0;
         line_in  = '0;
      end else begin
         match_in = (line_ff == compare_ff);
         stat_in  = match_in & compare_en_ff;
         if (mode_ff == lmts_pkg::MODE_XFER && !drawn_ff) begin
            drawn_in  = 1'b1;
            strobe_in = 1'b1;
         end
         // mode or line change when the current mode's dot budget is used up; vblank leaves only after the last line
         unique case (mode_ff)
            lmts_pkg::MODE_VBLANK: begin
               if (dot_ff == lmts_pkg::DOTS_LINE) begin
                  if (line_ff == lmts_pkg::LAST_LINE) begin
                     mode_in = lmts_pkg::MODE_OAM;
                     stat_in = stat_in | oam_en_ff;
                     line_in = '0;
                  end else begin
                     line_in = line_inc;
                  end
                  dot_base = '0;
                  drawn_in = 1'b0;
               end
            end
            lmts_pkg::MODE_OAM: begin
               if (dot_ff == lmts_pkg::DOTS_OAM) begin
                  mode_in  = lmts_pkg::MODE_XFER;
                  dot_base = '0;
                  drawn_in = 1'b0;
               end
            end
            lmts_pkg::MODE_XFER: begin
               if (dot_ff == lmts_pkg::DOTS_XFER) begin
                  mode_in  = lmts_pkg::MODE_HBLANK;
                  stat_in  = stat_in | hblank_en_ff;
                  dot_base = '0;
                  drawn_in = 1'b0;
               end
            end
            lmts_pkg::MODE_HBLANK: begin
               if (dot_ff == lmts_pkg::DOTS_HBLANK) begin
                  line_in = line_inc;
                  if (line_inc == lmts_pkg::FIRST_VBLANK) begin
                     mode_in = lmts_pkg::MODE_VBLANK;
                     stat_in = stat_in | vblank_en_ff;
                     vbl_in  = 1'b1;
                  end else begin
                     mode_in = lmts_pkg::MODE_OAM;
                     stat_in = stat_in | oam_en_ff;
                  end
                  dot_base = '0;
                  drawn_in = 1'b0;
               end
            end
            default: ;
         endcase
         dot_base = dot_base + 9'd1;
      end
      dot_in = dot_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= lmts_pkg::MODE_HBLANK;
         dot_ff   <= '0;
         line_ff  <= '0;
         drawn_ff <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         dot_ff   <= dot_in;
         line_ff  <= line_in;
         drawn_ff <= drawn_in;
      end
   end

   assign valid_in = accept | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         line_out_ff <= line_in;
         mode_out_ff <= mode_in;
         match_ff    <= match_in;
         stat_ff     <= stat_in;
         vbl_ff      <= vbl_in;
         strobe_ff   <= strobe_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_line_number      = line_out_ff;
   assign rsp_mode             = mode_out_ff;
   assign rsp_line_match       = match_ff;
   assign rsp_stat_irq         = stat_ff;
   assign rsp_vblank_irq       = vbl_ff;
   assign rsp_draw_line_strobe = strobe_ff;

endmodule

`default_nettype wire

### hdl/lcd_mode_timing_sequencer_checker.sv
// Port-level checks for lcd_mode_timing_sequencer_unit, attached by bind.
// Depends on lmts_pkg.
`default_nettype none

module lcd_mode_timing_sequencer_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_stall,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire [lmts_pkg::LINE_WIDTH-1:0]     rsp_line_number,
   input wire [1:0]                          rsp_mode,
   input wire                                rsp_vblank_irq,
   input wire                                rsp_draw_line_strobe
);

   // vblank mode only ever appears on lines 144..153
   vblank_lines: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode == lmts_pkg::MODE_VBLANK) |->
         (rsp_line_number >= lmts_pkg::FIRST_VBLANK &&
          rsp_line_number <= lmts_pkg::LAST_LINE))
      else $error("vblank mode outside vblank lines");

   vblank_pulse: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_vblank_irq) |->
         (rsp_mode == lmts_pkg::MODE_VBLANK &&
          rsp_line_number == lmts_pkg::FIRST_VBLANK))
      else $error("vblank pulse not on entry to line 144");

   strobe_in_xfer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_draw_line_strobe) |-> rsp_mode == lmts_pkg::MODE_XFER)
      else $error("draw strobe outside pixel transfer");

   // a held result blocks new ticks and keeps its line number and mode
   stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> ##0 req_stall ##1
         (rsp_valid && $stable(rsp_line_number) && $stable(rsp_mode)))
      else $error("stalled transaction changed or was dropped");

endmodule

bind lcd_mode_timing_sequencer_unit lcd_mode_timing_sequencer_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_line_number      (rsp_line_number),
   .rsp_mode             (rsp_mode),
   .rsp_vblank_irq       (rsp_vblank_irq),
   .rsp_draw_line_strobe (rsp_draw_line_strobe)
);

`default_nettype wire
